FILE: design/ell_pkg.sv
package ell_pkg;

   // token kinds as reported on the response channel
   localparam logic [4:0] TK_INT_LIT  = 5'd0;
   localparam logic [4:0] TK_FLOAT    = 5'd1;
   localparam logic [4:0] TK_DOUBLE   = 5'd2;
   localparam logic [4:0] TK_IDENT    = 5'd3;
   localparam logic [4:0] TK_KW_INT   = 5'd4;
   localparam logic [4:0] TK_KW_DBL   = 5'd5;
   localparam logic [4:0] TK_KW_FLT   = 5'd6;
   localparam logic [4:0] TK_KW_BOOL  = 5'd7;
   localparam logic [4:0] TK_BOOL_LIT = 5'd8;
   localparam logic [4:0] TK_PLUS     = 5'd9;
   localparam logic [4:0] TK_MINUS    = 5'd10;
   localparam logic [4:0] TK_ARROW    = 5'd11;
   localparam logic [4:0] TK_STAR     = 5'd12;
   localparam logic [4:0] TK_SLASH    = 5'd13;
   localparam logic [4:0] TK_LPAREN   = 5'd14;
   localparam logic [4:0] TK_RPAREN   = 5'd15;
   localparam logic [4:0] TK_ASSIGN   = 5'd16;
   localparam logic [4:0] TK_EQ       = 5'd17;
   localparam logic [4:0] TK_SEMI     = 5'd18;
   localparam logic [4:0] TK_GT       = 5'd19;
   localparam logic [4:0] TK_GE       = 5'd20;
   localparam logic [4:0] TK_LT       = 5'd21;
   localparam logic [4:0] TK_LE       = 5'd22;
   localparam logic [4:0] TK_NOT      = 5'd23;
   localparam logic [4:0] TK_NE       = 5'd24;
   localparam logic [4:0] TK_END      = 5'd25;
   localparam logic [4:0] TK_BAD      = 5'd26;
   localparam logic [4:0] TK_TWO_PT   = 5'd27;
   localparam logic [4:0] TK_NONE     = 5'd0;

   localparam logic [7:0] CHAR_LF = 8'h0A;

   // keyword candidate codes
   localparam logic [2:0] KW_NONE   = 3'd0;
   localparam logic [2:0] KW_INT    = 3'd1;
   localparam logic [2:0] KW_DOUBLE = 3'd2;
   localparam logic [2:0] KW_FLOAT  = 3'd3;
   localparam logic [2:0] KW_BOOL   = 3'd4;
   localparam logic [2:0] KW_TRUE   = 3'd5;
   localparam logic [2:0] KW_FALSE  = 3'd6;
   localparam logic [2:0] KW_F_PRE  = 3'd7;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_OP1,
      MODE_DONE
   } scan_mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [23:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [15:0] col;
      logic        last;
   } result_type;

   function automatic logic is_digit(logic [7:0] c);
      is_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // single-character operator kind, TK_NONE for anything else
   function automatic logic [4:0] op_kind(logic [7:0] c);
      case (c)
         "+": op_kind = TK_PLUS;
         "-": op_kind = TK_MINUS;
         "*": op_kind = TK_STAR;
         "/": op_kind = TK_SLASH;
         "(": op_kind = TK_LPAREN;
         ")": op_kind = TK_RPAREN;
         "=": op_kind = TK_ASSIGN;
         ";": op_kind = TK_SEMI;
         ">": op_kind = TK_GT;
         "<": op_kind = TK_LT;
         "!": op_kind = TK_NOT;
         default: op_kind = TK_NONE;
      endcase
   endfunction

   // operators that may take a second character
   function automatic logic op_can_extend(logic [7:0] c);
      op_can_extend = (c == "-") || (c == "=") || (c == ">") || (c == "<") || (c == "!");
   endfunction

   function automatic logic [2:0] kw_first(logic [7:0] c);
      case (c)
         "i": kw_first = KW_INT;
         "d": kw_first = KW_DOUBLE;
         "b": kw_first = KW_BOOL;
         "t": kw_first = KW_TRUE;
         "f": kw_first = KW_F_PRE;
         default: kw_first = KW_NONE;
      endcase
   endfunction

   function automatic logic [2:0] kw_len(logic [2:0] m);
      case (m)
         KW_INT:    kw_len = 3'd3;
         KW_DOUBLE: kw_len = 3'd6;
         KW_FLOAT:  kw_len = 3'd5;
         KW_BOOL:   kw_len = 3'd4;
         KW_TRUE:   kw_len = 3'd4;
         KW_FALSE:  kw_len = 3'd5;
         default:   kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [4:0] kw_kind(logic [2:0] m);
      case (m)
         KW_INT:    kw_kind = TK_KW_INT;
         KW_DOUBLE: kw_kind = TK_KW_DBL;
         KW_FLOAT:  kw_kind = TK_KW_FLT;
         KW_BOOL:   kw_kind = TK_KW_BOOL;
         KW_TRUE:   kw_kind = TK_BOOL_LIT;
         KW_FALSE:  kw_kind = TK_BOOL_LIT;
         default:   kw_kind = TK_IDENT;
      endcase
   endfunction

   // character at position i of a keyword, text held left-justified
   function automatic logic [7:0] kw_char(logic [2:0] m, logic [2:0] i);
      logic [47:0] w;
      case (m)
         KW_INT:    w = {"int", 24'h0};
         KW_DOUBLE: w = "double";
         KW_FLOAT:  w = {"float", 8'h0};
         KW_BOOL:   w = {"bool", 16'h0};
         KW_TRUE:   w = {"true", 16'h0};
         KW_FALSE:  w = {"false", 8'h0};
         default:   w = 48'h0;
      endcase
      w = w << {i, 3'b000};
      kw_char = w[47:40];
   endfunction

endpackage

FILE: design/expression_language_lexer_unit.sv
// output: a token's response is registered and shows in the cycle after the request that ends it
// throughput: one request per cycle while each yields at most one response, taken as it shows;
// a request that yields two (flush plus end or error) holds the next until the second is taken,
// set by the two-entry response queue; all scanning is combinational on the state registers
// reset: synchronous, active high; clears scan state, counters and the response queue at once
module expression_language_lexer_unit
   import ell_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int POS_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [23:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_last_of_run
);

   // scan state
   scan_mode_type         mode_ff, mode_in;
   logic                  seen_point_ff, seen_point_in;
   logic [4:0]            pend_kind_ff, pend_kind_in;
   logic [2:0]            kw_ff, kw_in;
   logic [OFFSET_BITS-1:0] token_start_ff, token_start_in;
   logic [15:0]           token_len_ff, token_len_in;
   logic [OFFSET_BITS-1:0] byte_count_ff, byte_count_in;
   logic [POS_BITS-1:0]   line_ff, line_in;
   logic [POS_BITS-1:0]   col_ff, col_in;
   logic                  error_hold_ff, error_hold_in;

   // response queue
   result_type            slot0_ff, slot0_in;
   result_type            slot1_ff, slot1_in;
   logic [1:0]            count_ff, count_in;

   logic                  accept, pop;
   logic [7:0]            c;
   logic                  eoi;
   logic                  c_dig, c_alp, c_spc, c_ext;
   logic [4:0]            c_op;
   logic [4:0]            two_kind;
   logic                  extend, flush, twopt, bad;
   logic [4:0]            fin_kind;
   logic [2:0]            kw_nx;
   logic [POS_BITS-1:0]   line_step, col_step;
   logic [15:0]           line_out, col_out;
   result_type            r0, r1;
   logic [1:0]            res_n;

   function automatic logic [15:0] clamp_pos(logic [POS_BITS-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      clamp_pos = (w > 33'h0_0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic logic [23:0] clamp_off(logic [OFFSET_BITS-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      clamp_off = (w > 33'h0_00FF_FFFF) ? 24'hFF_FFFF : w[23:0];
   endfunction

   function automatic logic [POS_BITS-1:0] inc_pos(logic [POS_BITS-1:0] v);
      inc_pos = (v == {POS_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] inc_off(logic [OFFSET_BITS-1:0] v);
      inc_off = (v == {OFFSET_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] inc_len(logic [15:0] v);
      inc_len = (v == 16'hFFFF) ? v : v + 1'b1;
   endfunction

   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign accept    = req_valid && req_ready;

   // character classes
   assign c     = req_byte_in;
   assign eoi   = req_end_of_input;
   assign c_dig = is_digit(c);
   assign c_alp = is_alpha(c);
   assign c_spc = is_space(c);
   assign c_op  = op_kind(c);
   assign c_ext = op_can_extend(c);

   // two-character operator completion
   always_comb begin
      two_kind = TK_NONE;
      if ((pend_kind_ff == TK_MINUS) && (c == ">")) begin
         two_kind = TK_ARROW;
      end else if (c == "=") begin
         case (pend_kind_ff)
            TK_ASSIGN: two_kind = TK_EQ;
            TK_GT:     two_kind = TK_GE;
            TK_LT:     two_kind = TK_LE;
            TK_NOT:    two_kind = TK_NE;
            default:   two_kind = TK_NONE;
         endcase
      end
   end

   // whether the byte continues the pending token
   always_comb begin
      case (mode_ff)
         MODE_NUM:   extend = c_dig || (c == ".") || (c == "f");
         MODE_IDENT: extend = c_alp;
         MODE_OP1:   extend = (two_kind != TK_NONE);
         default:    extend = 1'b0;
      endcase
   end

   assign flush = !extend && (mode_ff != MODE_IDLE);
   assign twopt = (mode_ff == MODE_NUM) && (c == ".") && seen_point_ff;
   assign bad   = !extend && !c_spc && !c_dig && !c_alp && (c_op == TK_NONE);

   // final kind of the pending token
   always_comb begin
      case (mode_ff)
         MODE_NUM: fin_kind = seen_point_ff ? TK_DOUBLE : TK_INT_LIT;
         MODE_IDENT: begin
            if ((kw_ff >= KW_INT) && (kw_ff <= KW_FALSE) &&
                (token_len_ff == {13'b0, kw_len(kw_ff)})) begin
               fin_kind = kw_kind(kw_ff);
            end else begin
               fin_kind = TK_IDENT;
            end
         end
         default: fin_kind = pend_kind_ff;
      endcase
   end

   // keyword tracking for the next letter
   always_comb begin
      kw_nx = KW_NONE;
      if (kw_ff == KW_F_PRE) begin
         if ((token_len_ff == 16'd1) && (c == "l")) begin
            kw_nx = KW_FLOAT;
         end else if ((token_len_ff == 16'd1) && (c == "a")) begin
            kw_nx = KW_FALSE;
         end
      end else if ((kw_ff != KW_NONE) && (token_len_ff < {13'b0, kw_len(kw_ff)}) &&
                   (kw_char(kw_ff, token_len_ff[2:0]) == c)) begin
         kw_nx = kw_ff;
      end
   end

   // position after the previous character is consumed
   always_comb begin
      col_step  = col_ff;
      line_step = line_ff;
      if (byte_count_ff != '0) begin
         col_step = inc_pos(col_ff);
         if (!eoi && (c == CHAR_LF)) begin
            col_step  = '0;
            line_step = inc_pos(line_ff);
         end
      end
   end

   assign line_out = error_hold_ff ? clamp_pos(line_ff) : clamp_pos(line_step);
   assign col_out  = error_hold_ff ? clamp_pos(col_ff) : clamp_pos(col_step);

   // responses caused by this request
   always_comb begin
      result_type pend_r, end_r, err_r;
      pend_r = '{kind: fin_kind, start: clamp_off(token_start_ff), len: token_len_ff,
                 line: line_out, col: col_out, last: 1'b0};
      end_r  = '{kind: TK_END, start: clamp_off(byte_count_ff), len: 16'd0,
                 line: line_out, col: col_out, last: 1'b1};
      err_r  = '{kind: (twopt ? TK_TWO_PT : TK_BAD), start: clamp_off(byte_count_ff),
                 len: 16'd0, line: line_out, col: col_out, last: 1'b1};
      r0    = end_r;
      r1    = end_r;
      res_n = 2'd0;
      if (eoi) begin
         if (!error_hold_ff && (mode_ff != MODE_IDLE)) begin
            r0    = pend_r;
            res_n = 2'd2;
         end else begin
            res_n = 2'd1;
         end
      end else if (!error_hold_ff) begin
         if (flush) begin
            r0 = pend_r;
            if (bad) begin
               r1    = err_r;
               res_n = 2'd2;
            end else begin
               r0.last = 1'b1;
               res_n   = 2'd1;
            end
         end else if (twopt || bad) begin
            r0    = err_r;
            res_n = 2'd1;
         end
      end
   end

   // next scan state
   always_comb begin
      mode_in        = mode_ff;
      seen_point_in  = seen_point_ff;
      pend_kind_in   = pend_kind_ff;
      kw_in          = kw_ff;
      token_start_in = token_start_ff;
      token_len_in   = token_len_ff;
      byte_count_in  = byte_count_ff;
      line_in        = line_ff;
      col_in         = col_ff;
      error_hold_in  = error_hold_ff;
      if (accept && eoi) begin
         mode_in        = MODE_IDLE;
         seen_point_in  = 1'b0;
         pend_kind_in   = TK_NONE;
         kw_in          = KW_NONE;
         token_start_in = '0;
         token_len_in   = 16'd0;
         byte_count_in  = '0;
         line_in        = POS_BITS'(1);
         col_in         = '0;
         error_hold_in  = 1'b0;
      end else if (accept && !error_hold_ff) begin
         line_in       = line_step;
         col_in        = col_step;
         byte_count_in = inc_off(byte_count_ff);
         case (mode_ff)
            MODE_NUM: begin
               if (c_dig) begin
                  token_len_in = inc_len(token_len_ff);
               end else if (c == ".") begin
                  if (seen_point_ff) begin
                     error_hold_in = 1'b1;
                  end else begin
                     seen_point_in = 1'b1;
                     token_len_in  = inc_len(token_len_ff);
                  end
               end else if (c == "f") begin
                  pend_kind_in = TK_FLOAT;
                  mode_in      = MODE_DONE;
               end
            end
            MODE_IDENT: begin
               if (c_alp) begin
                  kw_in        = kw_nx;
                  token_len_in = inc_len(token_len_ff);
               end
            end
            MODE_OP1: begin
               if (two_kind != TK_NONE) begin
                  pend_kind_in = two_kind;
                  token_len_in = 16'd2;
                  mode_in      = MODE_DONE;
               end
            end
            default: begin
            end
         endcase
         // start of a new token
         if (!extend) begin
            mode_in = MODE_IDLE;
            if (!c_spc) begin
               token_start_in = byte_count_ff;
               token_len_in   = 16'd1;
               seen_point_in  = 1'b0;
               kw_in          = KW_NONE;
               if (c_dig) begin
                  mode_in = MODE_NUM;
               end else if (c_alp) begin
                  mode_in = MODE_IDENT;
                  kw_in   = kw_first(c);
               end else if (c_op != TK_NONE) begin
                  pend_kind_in = c_op;
                  mode_in      = c_ext ? MODE_OP1 : MODE_DONE;
               end else begin
                  token_len_in  = 16'd0;
                  error_hold_in = 1'b1;
               end
            end
         end
      end
   end

   // response queue update
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (accept) begin
         slot0_in = r0;
         slot1_in = r1;
         count_in = res_n;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         seen_point_ff  <= 1'b0;
         pend_kind_ff   <= TK_NONE;
         kw_ff          <= KW_NONE;
         token_start_ff <= '0;
         token_len_ff   <= 16'd0;
         byte_count_ff  <= '0;
         line_ff        <= POS_BITS'(1);
         col_ff         <= '0;
         error_hold_ff  <= 1'b0;
         count_ff       <= 2'd0;
      end else begin
         mode_ff        <= mode_in;
         seen_point_ff  <= seen_point_in;
         pend_kind_ff   <= pend_kind_in;
         kw_ff          <= kw_in;
         token_start_ff <= token_start_in;
         token_len_ff   <= token_len_in;
         byte_count_ff  <= byte_count_in;
         line_ff        <= line_in;
         col_ff         <= col_in;
         error_hold_ff  <= error_hold_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // response ports
   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_token_kind    = slot0_ff.kind;
   assign rsp_start_offset  = slot0_ff.start;
   assign rsp_token_length  = slot0_ff.len;
   assign rsp_line_number   = slot0_ff.line;
   assign rsp_column_number = slot0_ff.col;
   assign rsp_last_of_run   = slot0_ff.last;

   // a request is taken only when the queue is empty after this cycle's pop
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff == 2'd0) || ((count_ff == 2'd1) && pop))
      else $error("request accepted into a busy response queue");

   // a response that is not last of its run must have its partner queued behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (count_ff == 2'd2))
      else $error("first response of a pair without its partner");

   // end of input returns the scanner to its reset state
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_input) |=>
         (mode_ff == MODE_IDLE) && (byte_count_ff == '0) && !error_hold_ff &&
         (line_ff == POS_BITS'(1)))
      else $error("scanner not cleared after end of input");

   // the line counter starts at one and never wraps to zero
   assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

endmodule
